### rtl/core/multi_slot_periodic_tick_scheduler_top_defines.svh
// Assertion macros shared by the tick scheduler RTL
`ifndef MULTI_SLOT_PERIODIC_TICK_SCHEDULER_TOP_DEFINES_SVH
`define MULTI_SLOT_PERIODIC_TICK_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define MSTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MSTS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/msts_pkg.sv
// Types and constants of the tick scheduler
`default_nettype none

package msts_pkg;

  localparam int ACT_W    = 3;
  localparam int RATE_W   = 16;
  localparam int MS_W     = 16;
  localparam int KIND_W   = 2;
  localparam int OIDX_W   = 3;
  localparam int COUNT_W  = 17;
  localparam int PERIOD_W = 10;

  // input actions
  localparam logic [ACT_W-1:0] ACT_TICK  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SCHED = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TERM  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RATE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SHUT  = 3'd4;

  // classified operations handed to the back end
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_SCHED = 3'd1;
  localparam logic [2:0] OP_TERM  = 3'd2;
  localparam logic [2:0] OP_RATE  = 3'd3;
  localparam logic [2:0] OP_SHUT  = 3'd4;
  localparam logic [2:0] OP_NOP   = 3'd5;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SCHEDULED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ACK       = 2'd3;

  localparam int RATE_DEFAULT  = 120;
  localparam int MS_PER_SECOND = 1000;
  localparam logic [COUNT_W-1:0]  MS_PER_SEC_DIVIDEND = COUNT_W'(MS_PER_SECOND);
  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = PERIOD_W'(MS_PER_SECOND / RATE_DEFAULT);
  localparam logic [PERIOD_W-1:0] MIN_PERIOD     = PERIOD_W'(1);
  localparam logic [RATE_W-1:0]   RATE_LIMIT     = RATE_W'(MS_PER_SECOND);

  typedef struct packed {
    logic [2:0]          op;
    logic [OIDX_W-1:0]   slot;
    logic                slot_ok;
    logic [PERIOD_W-1:0] rate_low;
    logic                rate_zero;
    logic                rate_big;
    logic [MS_W-1:0]     elapsed;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/msts_in_if.sv
// Input channel: one command word per handshake
`default_nettype none

interface msts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  slot;
  logic [15:0] rate;
  logic [15:0] elapsed_ms;

  modport source (output valid, action, slot, rate, elapsed_ms, input ready);
  modport sink   (input valid, action, slot, rate, elapsed_ms, output ready);
endinterface

`default_nettype wire

### rtl/core/msts_out_if.sv
// Output channel: one result word per handshake
`default_nettype none

interface msts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  slot_index;
  logic [16:0] fire_count;
  logic        last;

  modport source (output valid, kind, slot_index, fire_count, last, input ready);
  modport sink   (input valid, kind, slot_index, fire_count, last, output ready);
endinterface

`default_nettype wire

### rtl/core/msts_front.sv
// Front end: accepts command words, classifies them, two-entry queue
`default_nettype none

module msts_front
  import msts_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  msts_in_if.sink     in_ch,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  wire logic   q_pop
);

  cmd_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       push;

  always_comb begin
    cls           = '0;
    cls.slot      = in_ch.slot;
    cls.slot_ok   = int'(in_ch.slot) < NUM_SLOTS;
    cls.rate_low  = in_ch.rate[PERIOD_W-1:0];
    cls.rate_zero = in_ch.rate == '0;
    cls.rate_big  = in_ch.rate > RATE_LIMIT;
    cls.elapsed   = in_ch.elapsed_ms;
    unique case (in_ch.action)
      ACT_TICK:  cls.op = OP_TICK;
      ACT_SCHED: cls.op = OP_SCHED;
      ACT_TERM:  cls.op = OP_TERM;
      ACT_RATE:  cls.op = OP_RATE;
      ACT_SHUT:  cls.op = OP_SHUT;
      default:   cls.op = OP_NOP;
    endcase
  end

  assign in_ch.ready = count != 2'd2;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = count != 2'd0;
  assign q_cmd       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (q_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/msts_div.sv
// Shared restoring divider, two quotient bits per cycle
`default_nettype none

module msts_div
  import msts_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [COUNT_W-1:0]  dividend,
  input  wire logic [PERIOD_W-1:0] divisor,
  output logic                     done,
  output logic [COUNT_W-1:0]       quot,
  output logic [PERIOD_W-1:0]      rem
);

  localparam int QW    = COUNT_W + 1;
  localparam int STEPS = QW / 2;

  logic [QW-1:0]       q;
  logic [PERIOD_W-1:0] r;
  logic [PERIOD_W-1:0] d;
  logic [3:0]          cnt;
  logic                busy;
  logic [QW-1:0]       q_next;
  logic [PERIOD_W-1:0] r_next;

  always_comb begin
    logic [PERIOD_W:0] t;
    logic [QW-1:0]     qq;
    logic [PERIOD_W:0] rr;
    qq = q;
    rr = {1'b0, r};
    for (int s = 0; s < 2; s++) begin
      t  = {rr[PERIOD_W-1:0], qq[QW-1]};
      qq = {qq[QW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        qq[0] = 1'b1;
      end
      rr = t;
    end
    q_next = qq;
    r_next = rr[PERIOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= {1'b0, dividend};
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      q <= q_next;
      r <= r_next;
    end
  end

  // quotient never exceeds the 17-bit dividend, so the top bit stays clear
  assign quot = q[COUNT_W-1:0];
  assign rem  = r;

endmodule

`default_nettype wire

### rtl/core/msts_back.sv
// Back end: slot state, tick walk, period setup and result register
`default_nettype none

module msts_back
  import msts_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  input  wire cmd_t   q_cmd,
  output logic        q_pop,
  msts_out_if.source  out_ch
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_T_ISSUE = 4'd1;
  localparam logic [3:0] ST_T_WAIT  = 4'd2;
  localparam logic [3:0] ST_T_DIV   = 4'd3;
  localparam logic [3:0] ST_T_PUSH  = 4'd4;
  localparam logic [3:0] ST_T_END   = 4'd5;
  localparam logic [3:0] ST_SCAN    = 4'd6;
  localparam logic [3:0] ST_PER     = 4'd7;
  localparam logic [3:0] ST_P_DIV   = 4'd8;
  localparam logic [3:0] ST_RES     = 4'd9;

  logic [3:0]           state;
  cmd_t                 cmd;
  logic [IDX_W-1:0]     idx;
  logic [NUM_SLOTS-1:0] used;
  logic                 held_v;
  logic [OIDX_W-1:0]    held_idx;
  logic [COUNT_W-1:0]   held_cnt;
  logic [KIND_W-1:0]    res_kind;
  logic [OIDX_W-1:0]    res_idx;

  logic [PERIOD_W-1:0]  period_mem [NUM_SLOTS];
  logic [PERIOD_W-1:0]  accum_mem  [NUM_SLOTS];
  logic [PERIOD_W-1:0]  per_rd;
  logic [PERIOD_W-1:0]  acc_rd;
  logic                 per_we;
  logic [PERIOD_W-1:0]  per_wd;
  logic                 acc_we;
  logic [PERIOD_W-1:0]  acc_wd;

  logic                 div_start;
  logic [COUNT_W-1:0]   div_dividend;
  logic [PERIOD_W-1:0]  div_divisor;
  logic                 div_done;
  logic [COUNT_W-1:0]   div_quot;
  logic [PERIOD_W-1:0]  div_rem;

  logic                 out_free;
  logic                 emit;
  logic [KIND_W-1:0]    e_kind;
  logic [OIDX_W-1:0]    e_idx;
  logic [COUNT_W-1:0]   e_cnt;
  logic                 e_last;

  logic [IDX_W+2:0]     slot_ext;
  logic [IDX_W-1:0]     q_slot;
  logic [IDX_W+2:0]     idx_ext;
  logic [OIDX_W-1:0]    idx_out;
  logic                 at_last;

  assign slot_ext = {{IDX_W{1'b0}}, q_cmd.slot};
  assign q_slot   = slot_ext[IDX_W-1:0];
  assign idx_ext  = {3'b000, idx};
  assign idx_out  = idx_ext[OIDX_W-1:0];
  assign at_last  = idx == LAST_IDX;
  assign out_free = !out_ch.valid || out_ch.ready;

  msts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // slot memories: written at idx, read at idx with a registered port
  always_ff @(posedge clk) begin
    if (per_we) begin
      period_mem[idx] <= per_wd;
    end
    per_rd <= period_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      accum_mem[idx] <= acc_wd;
    end
    acc_rd <= accum_mem[idx];
  end

  always_comb begin
    q_pop        = 1'b0;
    emit         = 1'b0;
    e_kind       = KIND_ACK;
    e_idx        = '0;
    e_cnt        = '0;
    e_last       = 1'b1;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    per_we       = 1'b0;
    per_wd       = '0;
    acc_we       = 1'b0;
    acc_wd       = '0;
    unique case (state)
      ST_IDLE: q_pop = q_valid;
      ST_T_WAIT: begin
        div_start    = 1'b1;
        div_dividend = COUNT_W'(acc_rd) + COUNT_W'(cmd.elapsed);
        div_divisor  = per_rd;
      end
      ST_T_PUSH: begin
        acc_we = 1'b1;
        acc_wd = div_rem;
        // a new firing slot releases the one held back
        if (div_quot != '0 && held_v) begin
          emit   = out_free;
          e_kind = KIND_FIRED;
          e_idx  = held_idx;
          e_cnt  = held_cnt;
          e_last = 1'b0;
        end
      end
      ST_T_END: begin
        emit = out_free;
        if (held_v) begin
          e_kind = KIND_FIRED;
          e_idx  = held_idx;
          e_cnt  = held_cnt;
        end
      end
      ST_SCAN: begin
        if (!used[idx]) begin
          acc_we = 1'b1;
        end
      end
      ST_PER: begin
        if (cmd.rate_zero) begin
          per_we = 1'b1;
          per_wd = DEFAULT_PERIOD;
        end else if (cmd.rate_big) begin
          per_we = 1'b1;
          per_wd = MIN_PERIOD;
        end else begin
          div_start    = 1'b1;
          div_dividend = MS_PER_SEC_DIVIDEND;
          div_divisor  = cmd.rate_low;
        end
      end
      ST_P_DIV: begin
        if (div_done) begin
          per_we = 1'b1;
          per_wd = div_quot[PERIOD_W-1:0];
        end
      end
      ST_RES: begin
        emit   = out_free;
        e_kind = res_kind;
        e_idx  = res_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      used   <= '0;
      held_v <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd      <= q_cmd;
            idx      <= '0;
            held_v   <= 1'b0;
            res_kind <= KIND_ACK;
            res_idx  <= '0;
            case (q_cmd.op)
              OP_TICK:  state <= ST_T_ISSUE;
              OP_SCHED: state <= ST_SCAN;
              OP_TERM: begin
                if (q_cmd.slot_ok) begin
                  used[q_slot] <= 1'b0;
                end
                state <= ST_RES;
              end
              OP_RATE: begin
                if (q_cmd.slot_ok) begin
                  idx   <= q_slot;
                  state <= ST_PER;
                end else begin
                  state <= ST_RES;
                end
              end
              OP_SHUT: begin
                used  <= '0;
                state <= ST_RES;
              end
              default: state <= ST_RES;
            endcase
          end
        end
        ST_T_ISSUE: begin
          if (used[idx]) begin
            state <= ST_T_WAIT;
          end else if (at_last) begin
            state <= ST_T_END;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_T_WAIT: state <= ST_T_DIV;
        ST_T_DIV: begin
          if (div_done) begin
            state <= ST_T_PUSH;
          end
        end
        ST_T_PUSH: begin
          if (div_quot == '0 || !held_v || out_free) begin
            if (div_quot != '0) begin
              held_v   <= 1'b1;
              held_idx <= idx_out;
              held_cnt <= div_quot;
            end
            if (at_last) begin
              state <= ST_T_END;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= ST_T_ISSUE;
            end
          end
        end
        ST_T_END: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (!used[idx]) begin
            used[idx] <= 1'b1;
            res_kind  <= KIND_SCHEDULED;
            res_idx   <= idx_out;
            state     <= ST_PER;
          end else if (at_last) begin
            res_kind <= KIND_FULL;
            state    <= ST_RES;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_PER: begin
          if (cmd.rate_zero || cmd.rate_big) begin
            state <= ST_RES;
          end else begin
            state <= ST_P_DIV;
          end
        end
        ST_P_DIV: begin
          if (div_done) begin
            state <= ST_RES;
          end
        end
        ST_RES: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (emit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.kind       <= e_kind;
      out_ch.slot_index <= e_idx;
      out_ch.fire_count <= e_cnt;
      out_ch.last       <= e_last;
    end
  end

endmodule

`default_nettype wire

### rtl/core/multi_slot_periodic_tick_scheduler_top.sv
// Top level of the multi-slot periodic tick scheduler
// Usage:
//   in_ch carries one command word per handshake (valid and ready high at a
//   clock edge): tick, schedule, terminate, set rate or shutdown. out_ch
//   returns result words; the final word of each command has last set.
//   A two-entry command queue in the front end feeds the slot engine,
//   so in_ch keeps taking words while the engine is busy.
//   Terminate, shutdown and unknown actions answer with a single ack.
//   Set rate divides in the shared divider (9 steps of 2 bits) unless
//   the rate is 0 or above 1000; a slot out of range only acks.
//   Schedule takes the first free slot and sets its period the same way;
//   a full pool answers full. A tick walks every slot, dividing for each
//   used one; its earlier fire words leave mid-walk.
//   When out_ch stalls, the result register holds and the engine waits;
//   once the queue fills, in_ch drops ready.
//   Reset (rst, synchronous) frees every slot and empties the queue and
//   the result register; slot rates hold no value until written.
`default_nettype none

`include "multi_slot_periodic_tick_scheduler_top_defines.svh"

module multi_slot_periodic_tick_scheduler_top
  import msts_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  msts_in_if.sink     in_ch,
  msts_out_if.source  out_ch
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  msts_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  msts_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  `MSTS_ASSERT_IMP(a_pop_has_cmd, q_pop, q_valid, "queue popped while empty")
  `MSTS_ASSERT_NXT(a_one_cmd_at_a_time, q_pop, !q_pop, "engine took two commands back to back")
  `MSTS_ASSERT_IMP(a_fired_nonzero, out_ch.valid && out_ch.kind == KIND_FIRED, out_ch.fire_count != '0, "fired word with zero count")
  `MSTS_ASSERT_IMP(a_single_word_last, out_ch.valid && out_ch.kind != KIND_FIRED, out_ch.last && out_ch.fire_count == '0, "non-fire word not final or with count")

endmodule

`default_nettype wire

### bench/msts_result_checker.sv
// Scoreboard for the tick scheduler: mirrors slot state and checks every result word
`default_nettype none

module msts_result_checker
  import msts_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic clk,
  input  logic rst,
  msts_in_if   in_ch,
  msts_out_if  out_ch,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [OIDX_W-1:0]  slot_index;
    logic [COUNT_W-1:0] fire_count;
    logic               last;
  } result_word_t;

  result_word_t        due_words[$];
  logic                slot_live  [NUM_SLOTS];
  logic [RATE_W-1:0]   slot_tps   [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_carry [NUM_SLOTS];
  int                  mismatch_cnt = 0;

  // rate 0 runs at the default rate; rates above one per ms clamp to a 1 ms period
  function automatic int period_ms(input logic [RATE_W-1:0] tps);
    int eff;
    int p;
    eff = (tps == '0) ? RATE_DEFAULT : int'(tps);
    p = MS_PER_SECOND / eff;
    return (p == 0) ? 1 : p;
  endfunction

  function automatic result_word_t make_word(input logic [KIND_W-1:0] kind, input int idx,
                                             input int count, input logic last);
    result_word_t w;
    w.kind       = kind;
    w.slot_index = OIDX_W'(idx);
    w.fire_count = COUNT_W'(count);
    w.last       = last;
    return w;
  endfunction

  task automatic predict_command(input logic [ACT_W-1:0] action, input logic [OIDX_W-1:0] slot,
                                 input logic [RATE_W-1:0] rate, input logic [MS_W-1:0] elapsed);
    int counts [NUM_SLOTS];
    int last_fired;
    int free_idx;
    int p;
    int sum;
    last_fired = -1;
    free_idx   = -1;
    case (action)
      ACT_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          counts[i] = 0;
          if (slot_live[i]) begin
            p = period_ms(slot_tps[i]);
            sum = int'(slot_carry[i]) + int'(elapsed);
            counts[i] = sum / p;
            slot_carry[i] = PERIOD_W'(sum - counts[i] * p);
            if (counts[i] != 0) last_fired = i;
          end
        end
        if (last_fired < 0) begin
          due_words.push_back(make_word(KIND_ACK, 0, 0, 1'b1));
        end else begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (counts[i] != 0)
              due_words.push_back(make_word(KIND_FIRED, i, counts[i], i == last_fired));
          end
        end
      end
      ACT_SCHED: begin
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (!slot_live[i]) free_idx = i;
        end
        if (free_idx < 0) begin
          due_words.push_back(make_word(KIND_FULL, 0, 0, 1'b1));
        end else begin
          slot_live[free_idx]  = 1'b1;
          slot_tps[free_idx]   = rate;
          slot_carry[free_idx] = '0;
          due_words.push_back(make_word(KIND_SCHEDULED, free_idx, 0, 1'b1));
        end
      end
      ACT_TERM: begin
        if (int'(slot) < NUM_SLOTS) slot_live[slot] = 1'b0;
      end
      ACT_RATE: begin
        if (int'(slot) < NUM_SLOTS) slot_tps[slot] = rate;
      end
      ACT_SHUT: begin
        for (int i = 0; i < NUM_SLOTS; i++) slot_live[i] = 1'b0;
      end
      default: ;
    endcase
    // everything but tick and schedule answers with a single ack
    if (action != ACT_TICK && action != ACT_SCHED)
      due_words.push_back(make_word(KIND_ACK, 0, 0, 1'b1));
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_live[i]  = 1'b0;
        slot_tps[i]   = '0;
        slot_carry[i] = '0;
      end
      due_words.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_command(in_ch.action, in_ch.slot, in_ch.rate, in_ch.elapsed_ms);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.slot_index, out_ch.fire_count, out_ch.last};
        if (due_words.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected word: expected none, actual kind=%0d slot=%0d count=%0d last=%0d",
                   $time, got.kind, got.slot_index, got.fire_count, got.last);
        end else begin
          want = due_words.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("slot_index", want.slot_index, got.slot_index);
          check_field("fire_count", want.fire_count, got.fire_count);
          check_field("last", want.last, got.last);
        end
      end
    end
    outstanding <= due_words.size();
    mismatches  <= mismatch_cnt;
  end

endmodule

`default_nettype wire

### bench/multi_slot_periodic_tick_scheduler_top_tb.sv
// Testbench top for the tick scheduler: stimulus, handshake idling and the verdict
`default_nettype none

module multi_slot_periodic_tick_scheduler_top_tb;
  import msts_pkg::*;

  localparam int SLOT_COUNT        = 8;
  localparam int RANDOM_WORDS      = 400;
  localparam int CALM_TAIL         = 60;
  localparam int DRAIN_CYCLES      = 200;
  localparam int ACT_UNKNOWN_FIRST = 5;
  localparam int ACT_UNKNOWN_LAST  = 7;

  logic clk;
  logic rst;
  bit   calm = 1'b0;
  int   src_idle_odds = 0;
  int   sink_idle_odds = 0;
  int   mismatches;
  int   outstanding;

  msts_in_if  in_ch ();
  msts_out_if out_ch ();

  multi_slot_periodic_tick_scheduler_top #(
    .NUM_SLOTS(SLOT_COUNT)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  msts_result_checker #(
    .NUM_SLOTS(SLOT_COUNT)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("multi_slot_periodic_tick_scheduler_top_tb NOT OK");
    $finish;
  end

  // result side: random stall bursts, odds redrawn every 64 passes of the loop
  initial begin
    int cycle_no;
    cycle_no = 0;
    forever begin
      if (cycle_no % 64 == 0) sink_idle_odds = $urandom_range(0, 4);
      if (!calm && sink_idle_odds != 0 && $urandom_range(1, 8) <= sink_idle_odds) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      cycle_no++;
    end
  end

  // call just after clk rises; returns once valid and ready have taken the word
  task automatic send_word(input logic [ACT_W-1:0] action, input logic [OIDX_W-1:0] slot,
                           input logic [RATE_W-1:0] rate, input logic [MS_W-1:0] elapsed);
    if (!calm && src_idle_odds != 0 && $urandom_range(1, 8) <= src_idle_odds) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= action;
    in_ch.slot       <= slot;
    in_ch.rate       <= rate;
    in_ch.elapsed_ms <= elapsed;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    int                  pick;
    logic [ACT_W-1:0]    act;
    logic [RATE_W-1:0]   rate;
    logic [MS_W-1:0]     ms;

    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= '0;
    in_ch.slot       <= '0;
    in_ch.rate       <= '0;
    in_ch.elapsed_ms <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty pool: ticks only ack
    send_word(ACT_TICK, 3'd0, 16'd0, 16'd0);
    send_word(ACT_TICK, 3'd0, 16'd0, 16'hFFFF);
    // fill the pool across the period corners, then overflow it
    send_word(ACT_SCHED, 3'd0, 16'd0, 16'd0);
    send_word(ACT_SCHED, 3'd0, 16'd1, 16'd0);
    send_word(ACT_SCHED, 3'd0, 16'd1000, 16'd0);
    send_word(ACT_SCHED, 3'd0, 16'd1001, 16'd0);
    send_word(ACT_SCHED, 3'd0, 16'hFFFF, 16'd0);
    send_word(ACT_SCHED, 3'd0, 16'd7, 16'd0);
    send_word(ACT_SCHED, 3'd0, 16'd120, 16'd0);
    send_word(ACT_SCHED, 3'd0, 16'd999, 16'd0);
    send_word(ACT_SCHED, 3'd0, 16'd5, 16'd0);
    send_word(ACT_TICK, 3'd0, 16'd0, 16'd0);
    send_word(ACT_TICK, 3'd0, 16'd0, 16'd7);
    // slow slot sits one ms short of its period, then the widest tick
    send_word(ACT_TICK, 3'd0, 16'd0, 16'd992);
    send_word(ACT_TICK, 3'd0, 16'd0, 16'hFFFF);
    send_word(ACT_RATE, 3'd7, 16'hFFFF, 16'd0);
    send_word(ACT_TERM, 3'd3, 16'd0, 16'd0);
    send_word(ACT_RATE, 3'd3, 16'd500, 16'd0);
    send_word(ACT_SCHED, 3'd0, 16'd2, 16'd0);
    for (int k = ACT_UNKNOWN_FIRST; k <= ACT_UNKNOWN_LAST; k++)
      send_word(ACT_W'(k), OIDX_W'(k), 16'hFFFF, 16'hFFFF);
    send_word(ACT_TICK, 3'd0, 16'd0, 16'd1);
    send_word(ACT_SHUT, 3'd0, 16'd0, 16'd0);
    send_word(ACT_TICK, 3'd0, 16'd0, 16'd100);
    send_word(ACT_TERM, 3'd7, 16'd0, 16'd0);
    send_word(ACT_SCHED, 3'd0, 16'd0, 16'd0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) src_idle_odds = $urandom_range(0, 4);
      if (n >= RANDOM_WORDS - CALM_TAIL) calm = 1'b1;

      pick = $urandom_range(0, 99);
      if (pick < 40)      act = ACT_TICK;
      else if (pick < 62) act = ACT_SCHED;
      else if (pick < 76) act = ACT_TERM;
      else if (pick < 91) act = ACT_RATE;
      else if (pick < 95) act = ACT_SHUT;
      else                act = ACT_W'($urandom_range(ACT_UNKNOWN_FIRST, ACT_UNKNOWN_LAST));

      pick = $urandom_range(0, 99);
      if (pick < 15)      rate = '0;
      else if (pick < 55) rate = RATE_W'($urandom_range(1, 200));
      else if (pick < 75) rate = RATE_W'($urandom_range(201, 1000));
      else if (pick < 90) rate = RATE_W'($urandom_range(1001, 65535));
      else                rate = RATE_W'($urandom);

      // mostly frame-sized steps, now and then long gaps
      pick = $urandom_range(0, 99);
      if (pick < 5)       ms = '0;
      else if (pick < 55) ms = MS_W'($urandom_range(1, 20));
      else if (pick < 85) ms = MS_W'($urandom_range(0, 1100));
      else                ms = MS_W'($urandom);

      send_word(act, OIDX_W'($urandom_range(0, 7)), rate, ms);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("multi_slot_periodic_tick_scheduler_top_tb OK");
    else
      $display("multi_slot_periodic_tick_scheduler_top_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/msts_pkg.sv
rtl/core/msts_in_if.sv
rtl/core/msts_out_if.sv
rtl/core/msts_front.sv
rtl/core/msts_div.sv
rtl/core/msts_back.sv
rtl/core/multi_slot_periodic_tick_scheduler_top.sv
bench/msts_result_checker.sv
bench/multi_slot_periodic_tick_scheduler_top_tb.sv
